FILE: design/sha256_stream_hasher_unit_defines.svh
// Assertion macros used by the SHA-256 hasher controller.
// Depends on nothing; included by files that carry assertions.
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sha_pkg.sv
// Package for the SHA-256 hasher: constants, round functions, command struct.
// No dependencies.
package sha_pkg;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic       CMD_ABSORB = 1'b0;
    localparam logic       CMD_FINISH = 1'b1;

    // Byte source selects for the buffer write port
    localparam logic [1:0] WSRC_DATA = 2'd0;
    localparam logic [1:0] WSRC_PAD  = 2'd1;
    localparam logic [1:0] WSRC_ZERO = 2'd2;
    localparam logic [1:0] WSRC_LEN  = 2'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic       buf_we;
        logic [5:0] buf_addr;
        logic [1:0] wsrc;
        logic [7:0] data;
        logic       len_add;     // count 8 more message bits
        logic       load_abc;    // copy chain words into working vars
        logic       sched_load;  // schedule load flag; not read by the datapath
        logic [3:0] rd_addr;     // buffer word to prefetch
        logic       round_en;    // perform one round
        logic [5:0] round_idx;
        logic       chain_add;   // fold working vars into chain words
        logic       msg_reset;   // back to the initial vector
        logic [2:0] out_sel;
    } sha_cmd_t;

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
        ror = (v >> n) | (v << (32 - n));
    endfunction

endpackage

FILE: design/sha_datapath.sv
// SHA-256 datapath: block buffer, message schedule window, round unit, chain words.
// Depends on sha_pkg.
module sha_datapath
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  sha_cmd_t    cmd,
    output logic [31:0] word_out
);

    // Block buffer as 16 big-endian words, byte-lane writes, one registered word read
    logic [31:0] buf_mem [16];
    logic [7:0]  wbyte;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] rd_word_reg;
    logic [31:0] w_reg [16];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [31:0] chain_reg [8];
    logic [31:0] w_new, w_t, t1, t2, s0, s1, big0, big1, ch, maj;
    logic [2:0]  lsel;

    // Write byte selection; length bytes big-endian at 56..63
    assign lsel = 3'd7 - cmd.buf_addr[2:0];
    always_comb
    begin
        case (cmd.wsrc)
            WSRC_DATA: wbyte = cmd.data;
            WSRC_PAD:  wbyte = PAD_BYTE;
            WSRC_ZERO: wbyte = 8'h00;
            WSRC_LEN:  wbyte = bits_reg[{lsel, 3'b000} +: 8];
            default:   wbyte = 8'h00;
        endcase
    end

    // Buffer write; word read for the schedule load
    always_ff @(posedge clk)
    begin
        if (cmd.buf_we)
        begin
            buf_mem[cmd.buf_addr[5:2]][{~cmd.buf_addr[1:0], 3'b000} +: 8] <= wbyte;
        end
        rd_word_reg <= buf_mem[cmd.rd_addr];
    end

    // Message bit counter
    always_comb
    begin
        bits_next = bits_reg;
        if (cmd.msg_reset)
        begin
            bits_next = '0;
        end
        else if (cmd.len_add)
        begin
            bits_next = bits_reg + 64'd8;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
        end
    end

    // Schedule: 16-word window; next word from the buffer for rounds 0..15, else from the window
    assign s0 = ror(w_reg[1], 7) ^ ror(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = ror(w_reg[14], 17) ^ ror(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign w_t = (cmd.round_idx < 6'd16) ? rd_word_reg : w_new;

    always_ff @(posedge clk)
    begin
        if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_t;
        end
    end

    // One round per cycle
    assign big1 = ror(e_reg, 6) ^ ror(e_reg, 11) ^ ror(e_reg, 25);
    assign ch   = (e_reg & f_reg) ^ (~e_reg & g_reg);
    assign big0 = ror(a_reg, 2) ^ ror(a_reg, 13) ^ ror(a_reg, 22);
    assign maj  = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
    assign t1   = h_reg + big1 + ch + ROUND_K[cmd.round_idx] + w_t;
    assign t2   = big0 + maj;

    always_ff @(posedge clk)
    begin
        if (cmd.load_abc)
        begin
            a_reg <= chain_reg[0]; b_reg <= chain_reg[1];
            c_reg <= chain_reg[2]; d_reg <= chain_reg[3];
            e_reg <= chain_reg[4]; f_reg <= chain_reg[5];
            g_reg <= chain_reg[6]; h_reg <= chain_reg[7];
        end
        else if (cmd.round_en)
        begin
            h_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
        end
    end

    // Chain words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_H[i];
            end
        end
        else if (cmd.msg_reset)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= INIT_H[i];
            end
        end
        else if (cmd.chain_add)
        begin
            chain_reg[0] <= chain_reg[0] + a_reg; chain_reg[1] <= chain_reg[1] + b_reg;
            chain_reg[2] <= chain_reg[2] + c_reg; chain_reg[3] <= chain_reg[3] + d_reg;
            chain_reg[4] <= chain_reg[4] + e_reg; chain_reg[5] <= chain_reg[5] + f_reg;
            chain_reg[6] <= chain_reg[6] + g_reg; chain_reg[7] <= chain_reg[7] + h_reg;
        end
    end

    assign word_out = chain_reg[cmd.out_sel];

endmodule

FILE: design/sha_ctrl.sv
// SHA-256 controller: item handshake, padding sequence, round count, digest output.
// Depends on sha_pkg and the assertion macro header.
`include "sha256_stream_hasher_unit_defines.svh"
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       in_cmd,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] out_idx,
    output sha_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;  // write zero/length bytes
    localparam logic [2:0] ST_PREP  = 3'd2;  // load working vars, prefetch word 0
    localparam logic [2:0] ST_ROUND = 3'd3;
    localparam logic [2:0] ST_ADD   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_CLR   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [5:0] fill_reg, fill_next;     // next buffer slot; also pad pointer
    logic [5:0] rnd_reg, rnd_next;
    logic       fin_reg, fin_next;       // finishing message
    logic       two_reg, two_next;       // padding needs a second block
    logic [2:0] oidx_reg, oidx_next;
    logic       acc;

    assign in_stall = (state_reg != ST_IDLE);
    assign acc = in_valid && !in_stall;
    assign out_valid = (state_reg == ST_OUT);
    assign out_idx = oidx_reg;

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        rnd_next   = rnd_reg;
        fin_next   = fin_reg;
        two_next   = two_reg;
        oidx_next  = oidx_reg;
        cmd = '0;
        cmd.data = in_byte;
        cmd.round_idx = rnd_reg;
        cmd.out_sel = oidx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.buf_addr = fill_reg;
                if (acc && in_cmd == CMD_ABSORB)
                begin
                    cmd.buf_we = 1'b1;
                    cmd.wsrc = WSRC_DATA;
                    cmd.len_add = 1'b1;
                    fill_next = fill_reg + 6'd1;
                    if (fill_reg == 6'd63)
                    begin
                        fin_next = 1'b0;
                        state_next = ST_PREP;
                    end
                end
                else if (acc)
                begin
                    cmd.buf_we = 1'b1;
                    cmd.wsrc = WSRC_PAD;
                    fin_next = 1'b1;
                    two_next = (fill_reg > 6'd55);
                    fill_next = fill_reg + 6'd1;
                    state_next = (fill_reg == 6'd63) ? ST_PREP : ST_PAD;
                end
            end
            ST_PAD:
            begin
                cmd.buf_we = 1'b1;
                cmd.buf_addr = fill_reg;
                cmd.wsrc = (!two_reg && fill_reg >= 6'd56) ? WSRC_LEN : WSRC_ZERO;
                fill_next = fill_reg + 6'd1;
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.load_abc = 1'b1;
                cmd.round_idx = 6'd0;
                cmd.rd_addr = 4'd0;
                rnd_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                cmd.round_idx = rnd_reg;
                // Prefetch next buffer word for the following round
                cmd.rd_addr = rnd_reg[3:0] + 4'd1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                cmd.chain_add = 1'b1;
                fill_next = 6'd0;
                if (!fin_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (two_reg)
                begin
                    two_next = 1'b0;
                    state_next = ST_PAD;
                end
                else
                begin
                    oidx_next = 3'd0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next = ST_CLR;
                    end
                end
            end
            ST_CLR:
            begin
                cmd.msg_reset = 1'b1;
                fin_next = 1'b0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            rnd_reg   <= '0;
            fin_reg   <= 1'b0;
            two_reg   <= 1'b0;
            oidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rnd_reg   <= rnd_next;
            fin_reg   <= fin_next;
            two_reg   <= two_next;
            oidx_reg  <= oidx_next;
        end
    end

    `SHA_ASSERT_IMP(a_stall_busy, clk, rst_n, state_reg != ST_IDLE, in_stall, "not stalled while busy")
    `SHA_ASSERT_NEXT(a_round_end, clk, rst_n, state_reg == ST_ROUND && rnd_reg == 6'd63, state_reg == ST_ADD, "rounds did not end")
    `SHA_ASSERT_IMP(a_out_fin, clk, rst_n, state_reg == ST_OUT, fin_reg && !two_reg, "digest outside finish")
    `SHA_ASSERT_NEXT(a_last_clr, clk, rst_n, out_valid && !out_stall && oidx_reg == 3'd7, state_reg == ST_CLR, "no reset after last word")

endmodule

FILE: design/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher top level: joins controller and datapath.
// Depends on sha_pkg, sha_ctrl, sha_datapath.
//
// Use: the input channel (in_valid/in_stall, cmd, data_byte) takes one item
// at a time. cmd 0 absorbs data_byte into the block buffer. The 64th byte
// of a block starts a compression (a prep step, 64 rounds on the shared
// round unit, a fold step) during which in_stall is high. cmd 1 finishes:
// the padding bytes are written one per cycle into the block buffer, then
// one or two compressions follow. The digest leaves on the output channel
// (out_valid/out_stall) as eight items, word 0 first, last_word on word 7,
// one per cycle while not stalled; a stall simply holds the current word.
// After the last word a clear step returns the block to the initial vector,
// and it then takes the next item. Absorb rate is set by the round loop.
// Reset is asynchronous: chain words return to the initial vector, the
// length and fill count clear, the buffer contents stay undefined.
module sha256_stream_hasher_unit
    import sha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        cmd,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha_cmd_t dp_cmd;

    sha_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_cmd    (cmd),
        .in_byte   (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_idx   (word_index),
        .cmd       (dp_cmd)
    );

    sha_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dp_cmd),
        .word_out (digest_word)
    );

    assign last_word = (word_index == 3'd7);

endmodule
